@@ hdl/frd_pkg.sv @@
// ----------------------------------------------------------------------------
// frd_pkg
// Shared types and constants for the fraction reducer: payload structs and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package frd_pkg;

  // width of numerator and denominator
  localparam int WORD_BITS = 32;
  // counter width for shift count and divider step count
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // one input item
  typedef struct packed {
    logic signed [WORD_BITS-1:0] num_in;
    logic signed [WORD_BITS-1:0] den_in;
  } in_t;

  // one result item
  typedef struct packed {
    logic signed [WORD_BITS-1:0] num_out;
    logic signed [WORD_BITS-1:0] den_out;
    logic                        zero_over_zero;
  } out_t;

  // divider operand select
  typedef enum logic {
    SEL_NUM = 1'b0,
    SEL_DEN = 1'b1
  } div_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     strip;
    logic     gcd_step;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_step;
    logic     emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic strip_ok;
    logic gcd_done;
    logic div_last;
  } sts_t;

endpackage

@@ hdl/fraction_reducer.sv @@
// ----------------------------------------------------------------------------
// fraction_reducer
// Reduces a signed fraction to lowest terms by the gcd of its magnitudes.
// ----------------------------------------------------------------------------
// Usage:
//   An item (operands.num_in, operands.den_in) is taken at a clock edge with
//   start high and busy low. busy stays high until the result has been
//   produced; start is ignored meanwhile.
//   The result appears on result for exactly one cycle with done high. The
//   receiver cannot stall, so it must take the result in that cycle.
//   zero_over_zero flags 0/0, which returns 0/0.
// Sequence, from the accepting edge to done:
//   the common factors of two are stripped (at most WORD_BITS-1 of them),
//   then the binary gcd steps run, one shift or one subtract per cycle.
//   The two quotients then share one restoring divider, one bit per
//   cycle, numerator first and denominator second.
//   busy drops in the cycle done is high, so the next item can be taken
//   then; while an item is in progress no other is taken.
// Reset:
//   rst is synchronous; it returns the sequencer to idle and drops done.
// ----------------------------------------------------------------------------
module fraction_reducer (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  frd_pkg::in_t  operands,
  output frd_pkg::out_t result,
  output logic          done
);
  import frd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  frd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // arithmetic
  frd_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .cmd      (cmd),
    .sts      (sts),
    .result   (result),
    .done     (done)
  );

endmodule

@@ hdl/frd_ctrl.sv @@
// ----------------------------------------------------------------------------
// frd_ctrl
// Sequencer for the fraction reducer: common-factor stripping, binary gcd
// loop, then two passes through the shared divider and the result strobe.
// ----------------------------------------------------------------------------
module frd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  frd_pkg::sts_t sts,
  output frd_pkg::cmd_t cmd
);
  import frd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_STRIP  = 7'b0000010,
    ST_GCD    = 7'b0000100,
    ST_DIVN   = 7'b0001000,
    ST_DSTART = 7'b0010000,
    ST_DIVD   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.div_sel   = SEL_NUM;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (sts.strip_ok) begin
          cmd.strip = 1'b1;
        end else begin
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_NUM;
          state_next    = ST_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIVN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_DSTART;
        end
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_DEN;
        state_next    = ST_DIVD;
      end
      ST_DIVD: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // an accepted item always starts with the stripping phase
  a_start_strip: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_STRIP))
    else $error("accepted item did not enter stripping phase");

  // the result is emitted once and the block goes idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> (state == ST_IDLE))
    else $error("controller did not return to idle after emit");

  // the numerator divider pass only starts from the gcd phase; the denominator pass starts from the second start state
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVN && $past(state) != ST_DIVN) |-> $past(state) == ST_GCD)
    else $error("numerator division entered from wrong state");

endmodule

@@ hdl/frd_dpath.sv @@
// ----------------------------------------------------------------------------
// frd_dpath
// Datapath of the fraction reducer: magnitude capture, binary gcd registers,
// one shared restoring divider and the signed result register.
// ----------------------------------------------------------------------------
module frd_dpath (
  input  logic          clk,
  input  logic          rst,
  input  frd_pkg::in_t  operands,
  input  frd_pkg::cmd_t cmd,
  output frd_pkg::sts_t sts,
  output frd_pkg::out_t result,
  output logic          done
);
  import frd_pkg::*;

  word_t num_mag;
  word_t den_mag;
  word_t an;
  word_t ad;
  logic  neg_n;
  logic  neg_d;
  logic  zz;
  logic  one_zero;
  word_t a;
  word_t b;
  cnt_t  shift;
  word_t dvd;
  word_t dvs;
  word_t rem;
  word_t qn;
  cnt_t  cnt;
  logic [WORD_BITS:0] trial;
  logic               take;
  word_t              num_res;
  word_t              den_res;

  // input magnitudes, most negative value maps to 2^(WORD_BITS-1)
  assign num_mag = operands.num_in[WORD_BITS-1] ? word_t'(-operands.num_in)
                                                : word_t'(operands.num_in);
  assign den_mag = operands.den_in[WORD_BITS-1] ? word_t'(-operands.den_in)
                                                : word_t'(operands.den_in);

  // status towards the controller
  assign sts.strip_ok = !one_zero && !a[0] && !b[0];
  assign sts.gcd_done = (b == '0) && (a[0] || one_zero);
  assign sts.div_last = (cnt == cnt_t'(WORD_BITS - 1));

  // restoring divider trial subtract
  assign trial = {rem, dvd[WORD_BITS-1]};
  assign take  = (trial >= {1'b0, dvs});

  // operand capture and gcd loop
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an       <= num_mag;
      ad       <= den_mag;
      neg_n    <= operands.num_in[WORD_BITS-1];
      neg_d    <= operands.den_in[WORD_BITS-1];
      zz       <= (num_mag == '0) && (den_mag == '0);
      one_zero <= (num_mag == '0) || (den_mag == '0);
      shift    <= '0;
      // with one side zero the gcd is the other magnitude
      if ((num_mag == '0) || (den_mag == '0)) begin
        a <= num_mag | den_mag;
        b <= '0;
      end else begin
        a <= num_mag;
        b <= den_mag;
      end
    end else if (cmd.strip) begin
      a     <= a >> 1;
      b     <= b >> 1;
      shift <= shift + cnt_t'(1);
    end else if (cmd.gcd_step) begin
      if (!a[0]) begin
        a <= a >> 1;
      end else if (b == '0) begin
        a <= a;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a > b) begin
        a <= b;
        b <= a - b;
      end else begin
        b <= b - a;
      end
    end
  end

  // shared divider, dividend pre-shifted by the common power of two
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd <= (cmd.div_sel == SEL_DEN) ? (ad >> shift) : (an >> shift);
      dvs <= a;
      rem <= '0;
      cnt <= '0;
      if (cmd.div_sel == SEL_DEN) begin
        qn <= dvd;
      end
    end else if (cmd.div_step) begin
      rem <= take ? word_t'(trial - {1'b0, dvs}) : trial[WORD_BITS-1:0];
      dvd <= {dvd[WORD_BITS-2:0], take};
      cnt <= cnt + cnt_t'(1);
    end
  end

  // signed results
  assign num_res = neg_n ? word_t'(-qn)  : qn;
  assign den_res = neg_d ? word_t'(-dvd) : dvd;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.num_out        <= zz ? '0 : num_res;
      result.den_out        <= zz ? '0 : den_res;
      result.zero_over_zero <= zz;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  a_emit_strobe: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> done)
    else $error("emit did not raise the result strobe");

  a_zz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_over_zero) |-> (result.num_out == '0 && result.den_out == '0))
    else $error("zero over zero result not cleared");

  a_div_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (rem == '0 && cnt == '0))
    else $error("divider not cleared at start");

endmodule

@@ tb/fraction_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_checker
// Watches the item and result channels of the fraction reducer. Every
// accepted item is reduced by a local gcd model and queued; every result
// strobe is compared field by field with the oldest queued fraction.
// ----------------------------------------------------------------------------
module fraction_checker
  import frd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  in_t  operands,
  input  out_t result,
  input  logic done,
  output int   pending,
  output int   fail_count,
  output int   checked
);

  out_t expected_fractions[$];
  out_t want;

  // lowest terms of num/den by the gcd of the magnitudes, signs kept
  function automatic out_t reduce_fraction(in_t f);
    word_t an, ad, a, b, t, qn, qd;
    out_t  r;
    an = f.num_in[WORD_BITS-1] ? word_t'(-f.num_in) : word_t'(f.num_in);
    ad = f.den_in[WORD_BITS-1] ? word_t'(-f.den_in) : word_t'(f.den_in);
    r  = '0;
    if (an == '0 && ad == '0) begin
      r.zero_over_zero = 1'b1;
      return r;
    end
    // euclid on magnitudes; a zero side leaves the other magnitude as gcd
    a = an;
    b = ad;
    while (b != '0) begin
      t = a % b;
      a = b;
      b = t;
    end
    qn = an / a;
    qd = ad / a;
    r.num_out = f.num_in[WORD_BITS-1] ? -qn : qn;
    r.den_out = f.den_in[WORD_BITS-1] ? -qd : qd;
    return r;
  endfunction

  // compare the result first, then queue any item taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_fractions.size() == 0) begin
          $display("%0t: result with no item outstanding: got %0d/%0d zero_over_zero=%0b",
                   $time, result.num_out, result.den_out, result.zero_over_zero);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_fractions.pop_front();
          if (result.num_out !== want.num_out || result.den_out !== want.den_out ||
              result.zero_over_zero !== want.zero_over_zero) begin
            $display("%0t: mismatch: expected %0d/%0d zero_over_zero=%0b, got %0d/%0d zero_over_zero=%0b",
                     $time, want.num_out, want.den_out, want.zero_over_zero,
                     result.num_out, result.den_out, result.zero_over_zero);
            fail_count <= fail_count + 1;
          end
          checked <= checked + 1;
        end
      end
      if (start && !busy) begin
        expected_fractions.push_back(reduce_fraction(operands));
      end
      pending <= expected_fractions.size();
    end
  end

endmodule

@@ tb/tb_fraction_reducer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fraction_reducer
// Drives signed fractions into the fraction reducer: corner cases first
// (zeros, most negative and most positive words, sign mixes), then random
// fractions with shared factors, power-of-two factors and full-range words.
// A checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_fraction_reducer;
  import frd_pkg::*;

  localparam logic signed [WORD_BITS-1:0] MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [WORD_BITS-1:0] MOST_POS = ~MOST_NEG;
  localparam int RANDOM_ITEMS = 400;
  localparam int SETTLE_CYCLES = 4 * WORD_BITS + 64;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  in_t  operands;
  out_t result;
  logic done;
  int   pending;
  int   fail_count;
  int   checked;
  int   sent;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fraction_reducer u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .result   (result),
    .done     (done)
  );

  fraction_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operands   (operands),
    .result     (result),
    .done       (done),
    .pending    (pending),
    .fail_count (fail_count),
    .checked    (checked)
  );

  function automatic in_t make_fraction(logic signed [WORD_BITS-1:0] n,
                                        logic signed [WORD_BITS-1:0] d);
    in_t f;
    f.num_in = n;
    f.den_in = d;
    return f;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 1;
      2: return -1;
      3: return MOST_POS;
      4: return MOST_NEG;
      default: return $urandom;
    endcase
  endfunction

  // offer one item, sometimes after an idle spell, and hold it until taken
  task automatic send_fraction(input in_t f, input bit no_gaps);
    int idle;
    idle = 0;
    if (!no_gaps && $urandom_range(0, 99) < 27) begin
      idle = $urandom_range(1, 150);
    end
    repeat (idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    operands <= f;
    do begin
      @(posedge clk);
    end while (busy);
    sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // stimulus
  initial begin
    in_t corner_cases[$];
    logic signed [WORD_BITS-1:0] n, d;
    int unsigned g, a, b;
    int sh;

    sent     = 0;
    rst      <= 1'b1;
    start    <= 1'b0;
    operands <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // corner cases: zeros, extremes and sign mixes
    corner_cases.push_back(make_fraction(0, 0));
    corner_cases.push_back(make_fraction(0, 5));
    corner_cases.push_back(make_fraction(0, -5));
    corner_cases.push_back(make_fraction(7, 0));
    corner_cases.push_back(make_fraction(-7, 0));
    corner_cases.push_back(make_fraction(MOST_NEG, 0));
    corner_cases.push_back(make_fraction(0, MOST_NEG));
    corner_cases.push_back(make_fraction(MOST_NEG, MOST_NEG));
    corner_cases.push_back(make_fraction(MOST_NEG, 1));
    corner_cases.push_back(make_fraction(MOST_NEG, -1));
    corner_cases.push_back(make_fraction(1, MOST_NEG));
    corner_cases.push_back(make_fraction(MOST_NEG, -2));
    corner_cases.push_back(make_fraction(MOST_POS, MOST_POS));
    corner_cases.push_back(make_fraction(MOST_POS, MOST_NEG));
    corner_cases.push_back(make_fraction(MOST_POS, -MOST_POS));
    corner_cases.push_back(make_fraction(1, MOST_POS));
    corner_cases.push_back(make_fraction(-1, -1));
    corner_cases.push_back(make_fraction(12, 18));
    corner_cases.push_back(make_fraction(-12, 18));
    corner_cases.push_back(make_fraction(12, -18));
    corner_cases.push_back(make_fraction(-12, -18));
    corner_cases.push_back(make_fraction(1 <<< 30, 1 <<< 20));
    corner_cases.push_back(make_fraction(3 <<< 28, 6 <<< 20));
    foreach (corner_cases[i]) begin
      send_fraction(corner_cases[i], 1'b0);
    end
    wait_for_results();

    // random fractions; a stretch in the middle runs back to back
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom;
          d = $urandom;
        end
        4, 5, 6: begin
          g = $urandom_range(1, 65535);
          a = $urandom_range(0, 32767);
          b = $urandom_range(0, 32767);
          n = a * g;
          d = b * g;
          if ($urandom_range(0, 1)) n = -n;
          if ($urandom_range(0, 1)) d = -d;
        end
        7: begin
          sh = $urandom_range(0, 30);
          n  = ($urandom_range(0, 3) * 2 + 1) << sh;
          sh = $urandom_range(0, 30);
          d  = ($urandom_range(0, 3) * 2 + 1) << sh;
          if ($urandom_range(0, 1)) n = -n;
          if ($urandom_range(0, 1)) d = -d;
        end
        8: begin
          n = pick_extreme();
          d = pick_extreme();
        end
        default: begin
          n = $urandom_range(0, 40) - 20;
          d = $urandom_range(0, 40) - 20;
        end
      endcase
      if (i == 300) wait_for_results();
      send_fraction(make_fraction(n, d), i >= 150 && i < 250);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d fractions: corner cases, shared and power-of-two factors, full-range words.",
             sent);
    $display("Compared %0d reduced results, %0d of them wrong.", checked, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Run timed out with %0d results outstanding.", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/frd_pkg.sv
hdl/frd_ctrl.sv
hdl/frd_dpath.sv
hdl/fraction_reducer.sv
tb/fraction_checker.sv
tb/tb_fraction_reducer.sv
